// File: rtl/hsv2rgb_pkg.sv
`default_nettype none

package hsv2rgb_pkg;

  localparam logic [2:0] SEC_RED_GRN = 3'd0;
  localparam logic [2:0] SEC_GRN_RED = 3'd1;
  localparam logic [2:0] SEC_GRN_BLU = 3'd2;
  localparam logic [2:0] SEC_BLU_GRN = 3'd3;
  localparam logic [2:0] SEC_BLU_RED = 3'd4;
  localparam logic [2:0] SEC_RED_BLU = 3'd5;

  localparam int NQ_W   = 23;
  localparam int RC_W   = 18;
  localparam int RC_SH  = 32;
  localparam int PROD_W = NQ_W + RC_W;

  localparam logic [NQ_W-1:0] DIV_DEN    = 23'd30600;
  localparam logic [RC_W-1:0] DIV_RECIP  = 18'd140358;
  localparam logic [NQ_W-1:0] NONE_SCALE = 23'd120;
  localparam logic [NQ_W-1:0] HALF_DEN   = 23'd15300;

endpackage

`default_nettype wire

// File: rtl/hsv_to_rgb.sv
// HSV to RGB color converter, one color per transaction.
// Input channel: in_valid / in_stall with hue (1/2^HUE_FRACTION_BITS degree
// units, clamped to 360 degrees, 360 wraps to the red sector), saturation
// and value (8-bit fractions, 255 = 1.0).
// Output channel: out_valid / out_stall with red, green, blue (0..255,
// rounded half up).
// Throughput: one transaction per clock while out_stall is low; the six
// register stages each hold one item and advance independently, so an
// empty stage keeps accepting.
// The per-channel divide by 255 * sector width is a reciprocal multiply
// with a one-step correction spread over stages 4 to 6.
// Reset (rst, synchronous) empties every stage; out_valid drops next cycle.
// While out_stall is high the output holds; upstream stages keep filling
// until the pipeline is full, then in_stall rises. Nothing is lost or
// repeated across a stall.
`default_nettype none

module hsv_to_rgb #(
  parameter int HUE_FRACTION_BITS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [14:0] hue,
  input  wire logic [7:0]  saturation,
  input  wire logic [7:0]  value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);

  localparam longint P   = longint'(60) << HUE_FRACTION_BITS;
  localparam longint HL  = 6 * P;
  localparam int WW      = $clog2(P + 1);
  localparam int TW      = WW + 1;
  localparam int LW      = $clog2(HL + 1);
  localparam int HX      = (LW > 15) ? LW : 15;
  localparam int PRW     = 8 + WW;
  localparam int SW      = $clog2(255 * P + 1);
  localparam int NW      = $clog2(511 * 255 * P + 1);

  logic [6:1] v;
  logic [6:1] adv;

  always_comb begin
    adv[6] = !v[6] || !out_stall;
    for (int i = 5; i >= 1; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = v[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) v[1] <= in_valid;
      for (int i = 2; i <= 6; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage 1: clamp hue, find sector and weight
  logic [HX-1:0] hc;
  logic [HX-1:0] base;
  logic [2:0]    sec_c;
  logic [TW-1:0] t_c;
  logic [WW-1:0] w_c;

  always_comb begin
    hc = (HX'(hue) > HX'(HL)) ? HX'(HL) : HX'(hue);
    if (hc >= HX'(6 * P)) begin
      sec_c = hsv2rgb_pkg::SEC_RED_GRN;
      base  = HX'(6 * P);
    end else if (hc >= HX'(5 * P)) begin
      sec_c = hsv2rgb_pkg::SEC_RED_BLU;
      base  = HX'(4 * P);
    end else if (hc >= HX'(4 * P)) begin
      sec_c = hsv2rgb_pkg::SEC_BLU_RED;
      base  = HX'(4 * P);
    end else if (hc >= HX'(3 * P)) begin
      sec_c = hsv2rgb_pkg::SEC_BLU_GRN;
      base  = HX'(2 * P);
    end else if (hc >= HX'(2 * P)) begin
      sec_c = hsv2rgb_pkg::SEC_GRN_BLU;
      base  = HX'(2 * P);
    end else if (hc >= HX'(P)) begin
      sec_c = hsv2rgb_pkg::SEC_GRN_RED;
      base  = '0;
    end else begin
      sec_c = hsv2rgb_pkg::SEC_RED_GRN;
      base  = '0;
    end
    t_c = TW'(hc - base);
    w_c = (t_c >= TW'(P)) ? WW'(TW'(2 * P) - t_c) : WW'(t_c);
  end

  logic [2:0]    sec1;
  logic [WW-1:0] w1;
  logic [7:0]    sat1;
  logic [7:0]    val1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sec1 <= sec_c;
      w1   <= w_c;
      sat1 <= saturation;
      val1 <= value;
    end
  end

  // stage 2: products of saturation
  logic [2:0]     sec2;
  logic [7:0]     val2;
  logic [PRW-1:0] pw2;
  logic [SW-1:0]  cp2;
  logic [15:0]    vc2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sec2 <= sec1;
      val2 <= val1;
      pw2  <= PRW'(sat1) * PRW'(w1);
      cp2  <= SW'(8'd255 - sat1) * SW'(P);
      vc2  <= 16'(val1) * 16'(8'd255 - sat1);
    end
  end

  // stage 3: rounded numerators; the weighted one is scaled down by the hue fraction
  logic [SW-1:0] sum3;
  logic [NW-1:0] nf3;

  always_comb begin
    sum3 = SW'(pw2) + cp2;
    nf3  = NW'(2) * NW'(val2) * NW'(sum3) + NW'(255 * P);
  end

  logic [2:0]                   sec3;
  logic [7:0]                   val3;
  logic [hsv2rgb_pkg::NQ_W-1:0] np3;
  logic [hsv2rgb_pkg::NQ_W-1:0] nn3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      sec3 <= sec2;
      val3 <= val2;
      np3  <= hsv2rgb_pkg::NQ_W'(nf3 >> HUE_FRACTION_BITS);
      nn3  <= hsv2rgb_pkg::NQ_W'(vc2) * hsv2rgb_pkg::NONE_SCALE + hsv2rgb_pkg::HALF_DEN;
    end
  end

  // stage 4: quotient estimate by reciprocal
  logic [hsv2rgb_pkg::PROD_W-1:0] pr_p;
  logic [hsv2rgb_pkg::PROD_W-1:0] pr_n;

  assign pr_p = hsv2rgb_pkg::PROD_W'(np3) * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::DIV_RECIP);
  assign pr_n = hsv2rgb_pkg::PROD_W'(nn3) * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::DIV_RECIP);

  logic [2:0]                   sec4;
  logic [7:0]                   val4;
  logic [hsv2rgb_pkg::NQ_W-1:0] np4;
  logic [hsv2rgb_pkg::NQ_W-1:0] nn4;
  logic [7:0]                   qp4;
  logic [7:0]                   qn4;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sec4 <= sec3;
      val4 <= val3;
      np4  <= np3;
      nn4  <= nn3;
      qp4  <= pr_p[hsv2rgb_pkg::RC_SH+7:hsv2rgb_pkg::RC_SH];
      qn4  <= pr_n[hsv2rgb_pkg::RC_SH+7:hsv2rgb_pkg::RC_SH];
    end
  end

  // stage 5: multiply back the estimate
  logic [2:0]                   sec5;
  logic [7:0]                   val5;
  logic [hsv2rgb_pkg::NQ_W-1:0] np5;
  logic [hsv2rgb_pkg::NQ_W-1:0] nn5;
  logic [7:0]                   qp5;
  logic [7:0]                   qn5;
  logic [hsv2rgb_pkg::NQ_W-1:0] mp5;
  logic [hsv2rgb_pkg::NQ_W-1:0] mn5;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      sec5 <= sec4;
      val5 <= val4;
      np5  <= np4;
      nn5  <= nn4;
      qp5  <= qp4;
      qn5  <= qn4;
      mp5  <= hsv2rgb_pkg::NQ_W'(qp4) * hsv2rgb_pkg::DIV_DEN;
      mn5  <= hsv2rgb_pkg::NQ_W'(qn4) * hsv2rgb_pkg::DIV_DEN;
    end
  end

  // stage 6: correct, clamp, place channels by sector
  logic [hsv2rgb_pkg::NQ_W-1:0] rem_p;
  logic [hsv2rgb_pkg::NQ_W-1:0] rem_n;
  logic [8:0]                   qfp;
  logic [8:0]                   qfn;
  logic [7:0]                   part;
  logic [7:0]                   none;
  logic [7:0]                   r_c;
  logic [7:0]                   g_c;
  logic [7:0]                   b_c;

  always_comb begin
    rem_p = np5 - mp5;
    rem_n = nn5 - mn5;
    qfp   = 9'(qp5) + 9'(rem_p >= hsv2rgb_pkg::DIV_DEN);
    qfn   = 9'(qn5) + 9'(rem_n >= hsv2rgb_pkg::DIV_DEN);
    part  = qfp[8] ? 8'd255 : qfp[7:0];
    none  = qfn[8] ? 8'd255 : qfn[7:0];
    case (sec5)
      hsv2rgb_pkg::SEC_RED_GRN: begin
        r_c = val5; g_c = part; b_c = none;
      end
      hsv2rgb_pkg::SEC_GRN_RED: begin
        r_c = part; g_c = val5; b_c = none;
      end
      hsv2rgb_pkg::SEC_GRN_BLU: begin
        r_c = none; g_c = val5; b_c = part;
      end
      hsv2rgb_pkg::SEC_BLU_GRN: begin
        r_c = none; g_c = part; b_c = val5;
      end
      hsv2rgb_pkg::SEC_BLU_RED: begin
        r_c = part; g_c = none; b_c = val5;
      end
      default: begin
        r_c = val5; g_c = none; b_c = part;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      red   <= r_c;
      green <= g_c;
      blue  <= b_c;
    end
  end

  a_corr_one_step: assert property (@(posedge clk) disable iff (rst)
    v[5] |-> (rem_p < hsv2rgb_pkg::NQ_W'(2 * 30600)) && (rem_n < hsv2rgb_pkg::NQ_W'(2 * 30600)))
    else $error("reciprocal estimate off by more than one");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    v[6] && !out_stall && v[5] |=> v[6])
    else $error("item lost between last stages");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int HFB = 6;
  localparam int SECTOR = 60 << HFB;
  localparam int HUE_SPAN = 6 * SECTOR;
  localparam int LATENCY = 6;
  localparam int QUIET_LIMIT = 1000;
  localparam int RAND_ITEMS = 1080;
  localparam int NDIR = 25;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic        typed;
    rgb_t        want;
  } row_t;

  // typed rows: black, primaries and secondaries, hue at and above 360, gray
  localparam row_t DIRECTED [NDIR] = '{
    {15'd0,     8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    {15'd0,     8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
    {15'd3840,  8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0},
    {15'd7680,  8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},
    {15'd11520, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255},
    {15'd15360, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
    {15'd19200, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd255},
    {15'd23040, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
    {15'd32767, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
    {15'd23041, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
    {15'd12345, 8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
    {15'd32767, 8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    {15'd23040, 8'd100, 8'd200, 1'b0, 24'd0},
    {15'd1920,  8'd255, 8'd255, 1'b0, 24'd0},
    {15'd1920,  8'd255, 8'd1,   1'b0, 24'd0},
    {15'd5760,  8'd128, 8'd77,  1'b0, 24'd0},
    {15'd9600,  8'd200, 8'd255, 1'b0, 24'd0},
    {15'd13440, 8'd1,   8'd254, 1'b0, 24'd0},
    {15'd17280, 8'd254, 8'd1,   1'b0, 24'd0},
    {15'd21120, 8'd127, 8'd128, 1'b0, 24'd0},
    {15'd3839,  8'd255, 8'd255, 1'b0, 24'd0},
    {15'd3841,  8'd255, 8'd255, 1'b0, 24'd0},
    {15'd23039, 8'd255, 8'd255, 1'b0, 24'd0},
    {15'd16383, 8'd170, 8'd85,  1'b0, 24'd0},
    {15'd21845, 8'd85,  8'd170, 1'b0, 24'd0}
  };

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [14:0] hue;
  logic [7:0] saturation;
  logic [7:0] value;
  logic out_valid;
  logic out_stall;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  rgb_t color_q [$];
  int errors = 0;
  int send_calm = 0;
  int take_calm = 0;

  always #10 clk = ~clk;

  hsv_to_rgb #(
    .HUE_FRACTION_BITS(HFB)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .hue(hue),
    .saturation(saturation),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red(red),
    .green(green),
    .blue(blue)
  );

  function automatic logic [7:0] scaled_level(logic [7:0] v, logic [7:0] s,
                                              longint unsigned k);
    longint unsigned vv, ss, num, den, q;
    vv = v;
    ss = s;
    num = vv * (ss * k + (255 - ss) * SECTOR);
    den = 255 * SECTOR;
    q = (2 * num + den) / (2 * den);
    return (q > 255) ? 8'hFF : 8'(q);
  endfunction

  function automatic rgb_t hsv_color(logic [14:0] h_in, logic [7:0] s, logic [7:0] v);
    longint unsigned h, t, d, w;
    logic [2:0] sec;
    logic [7:0] full, part, none;
    rgb_t c;
    h = h_in;
    if (h > HUE_SPAN) h = HUE_SPAN;
    sec = (h == HUE_SPAN) ? hsv2rgb_pkg::SEC_RED_GRN : 3'(h / SECTOR);
    t = h % (2 * SECTOR);
    d = (t >= SECTOR) ? (t - SECTOR) : (SECTOR - t);
    w = SECTOR - d;
    full = scaled_level(v, s, SECTOR);
    part = scaled_level(v, s, w);
    none = scaled_level(v, s, 0);
    c = '0;
    case (sec)
      hsv2rgb_pkg::SEC_RED_GRN: c = '{full, part, none};
      hsv2rgb_pkg::SEC_GRN_RED: c = '{part, full, none};
      hsv2rgb_pkg::SEC_GRN_BLU: c = '{none, full, part};
      hsv2rgb_pkg::SEC_BLU_GRN: c = '{none, part, full};
      hsv2rgb_pkg::SEC_BLU_RED: c = '{part, none, full};
      hsv2rgb_pkg::SEC_RED_BLU: c = '{full, none, part};
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic int wait_cycles(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  task automatic report(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_color(logic [14:0] h, logic [7:0] s, logic [7:0] v, rgb_t want);
    int gap;
    gap = wait_cycles(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    hue <= h;
    saturation <= s;
    value <= v;
    do @(posedge clk); while (in_stall);
    color_q.push_back(want);
  endtask

  initial begin
    row_t row;
    logic [14:0] h;
    logic [7:0] s, v;
    rst <= 1'b1;
    in_valid <= 1'b0;
    hue <= '0;
    saturation <= '0;
    value <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NDIR; i++) begin
      row = DIRECTED[i];
      send_color(row.hue, row.sat, row.val,
                 row.typed ? row.want : hsv_color(row.hue, row.sat, row.val));
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) begin
        // hold off until the pipeline has drained
        in_valid <= 1'b0;
        do @(posedge clk); while (color_q.size() != 0);
      end
      case ($urandom_range(0, 7))
        0: h = 15'($urandom_range(HUE_SPAN + 1, 32767));
        1: h = 15'(SECTOR * $urandom_range(0, 6));
        default: h = 15'($urandom_range(0, HUE_SPAN));
      endcase
      s = 8'($urandom_range(0, 255));
      v = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) s = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      send_color(h, s, v, hsv_color(h, s, v));
    end

    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (3 * LATENCY) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    int gap;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = wait_cycles(take_calm);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    if (!rst && out_valid && !out_stall) begin
      if (color_q.size() == 0) begin
        report($sformatf("transaction %0d/%0d/%0d with nothing pending", red, green, blue));
      end else begin
        want = color_q.pop_front();
        if (red !== want.r) report($sformatf("red %0d, want %0d", red, want.r));
        if (green !== want.g) report($sformatf("green %0d, want %0d", green, want.g));
        if (blue !== want.b) report($sformatf("blue %0d, want %0d", blue, want.b));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

endmodule

// File: hsv_to_rgb.f
rtl/hsv2rgb_pkg.sv
rtl/hsv_to_rgb.sv
test/testbench.sv
